@@ hdl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, off during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check.
`define TBGD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Implication checked on the next edge.
`define TBGD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/tbgd_pkg.sv @@
// ---------------------------------------------------------------------------
// tbgd_pkg
// Types, register indexes, event codes and helpers of the gesture decoder.
// ---------------------------------------------------------------------------
package tbgd_pkg;

	localparam int TMR_W     = 16;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;
	localparam int TAP_W     = 3;

	localparam logic [CFG_IDX_W-1:0] REG_CHORD_HOLD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_A_REPEAT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_B_REPEAT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TAP_WINDOW = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD       = 3'd4;

	localparam logic [CFG_W-1:0] RST_CHORD_HOLD = 16'd400;
	localparam logic [CFG_W-1:0] RST_A_REPEAT   = 16'd300;
	localparam logic [CFG_W-1:0] RST_B_REPEAT   = 16'd600;
	localparam logic [CFG_W-1:0] RST_TAP_WINDOW = 16'd350;
	localparam logic [CFG_W-1:0] RST_HOLD       = 16'd500;

	localparam logic [1:0] BEV_NONE     = 2'd0;
	localparam logic [1:0] BEV_PRESS    = 2'd1;
	localparam logic [1:0] BEV_HOLD     = 2'd2;
	localparam logic [1:0] BEV_HOLD_ALT = 2'd3;

	localparam logic [2:0] AEV_NONE        = 3'd0;
	localparam logic [2:0] AEV_SINGLE      = 3'd1;
	localparam logic [2:0] AEV_TRIPLE      = 3'd2;
	localparam logic [2:0] AEV_QUAD        = 3'd3;
	localparam logic [2:0] AEV_HOLD        = 3'd4;
	localparam logic [2:0] AEV_HOLD_ALT    = 3'd5;
	localparam logic [2:0] AEV_HOLD_REPEAT = 3'd6;

	localparam logic [TAP_W-1:0] TAP_ONE   = 3'd1;
	localparam logic [TAP_W-1:0] TAP_TWO   = 3'd2;
	localparam logic [TAP_W-1:0] TAP_THREE = 3'd3;
	localparam logic [TAP_W-1:0] TAP_MAX   = 3'd4;

	typedef struct packed {
		logic a_down;
		logic b_down;
	} tbgd_in_t;

	typedef struct packed {
		logic       chord_event;
		logic [1:0] b_event;
		logic [2:0] a_event;
	} tbgd_out_t;

	function automatic logic [TMR_W-1:0] sat_inc(input logic [TMR_W-1:0] v);
		return (&v) ? v : v + TMR_W'(1);
	endfunction

	function automatic logic [TAP_W-1:0] tap_inc(input logic [TAP_W-1:0] t);
		return (t >= TAP_MAX) ? TAP_MAX : t + TAP_W'(1);
	endfunction

endpackage

@@ hdl/two_button_gesture_decoder.sv @@
// ---------------------------------------------------------------------------
// two_button_gesture_decoder
// Per-tick decoder of two button levels into chord, B and A gesture events.
// ---------------------------------------------------------------------------
//  channel | handshake              | payload
//  in      | in_valid / in_ready    | in_data  (a_down, b_down)
//  out     | out_valid / out_ready  | out_data (chord_event, b_event, a_event)
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
//  One sample per cycle unless stalled; stages: input register, result register.
//  All gesture state updates in one pass between the input and result registers.
//  out_ready low stalls the result register; one more request is held in the
//  input register, then in_ready drops. cfg_ready is always high. arst_n loads
//  the default register values, presets release timers to ones, clears the rest.
// ---------------------------------------------------------------------------
module two_button_gesture_decoder
	import tbgd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  tbgd_in_t             in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output tbgd_out_t            out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic [CFG_W-1:0] chord_cfg_q, a_rep_cfg_q, b_rep_cfg_q, tap_win_cfg_q, hold_cfg_q;

	tbgd_in_t  in_s1;
	logic      in_valid_s1;
	tbgd_out_t out_q;
	logic      out_valid_q;

	logic             a_prev_q, b_prev_q, a_seen_q, b_seen_q;
	logic             chord_fired_q, a_held_q, b_held_q, a_alt_q, b_alt_q, a_pend_q;
	logic [TMR_W-1:0] a_press_q, b_press_q, chord_tmr_q;
	logic [TMR_W-1:0] a_srep_q, b_srep_q, a_srel_q, b_srel_q;
	logic [TAP_W-1:0] a_taps_q, b_taps_q;

	logic             n_a_seen, n_b_seen, n_cf, n_a_held, n_b_held;
	logic             n_a_alt, n_b_alt, n_a_pend;
	logic [TMR_W-1:0] n_a_press, n_b_press, n_ct, n_a_srep, n_b_srep, n_a_srel, n_b_srel;
	logic [TAP_W-1:0] n_a_taps, n_b_taps;
	tbgd_out_t        res;
	logic             advance;

	assign advance   = in_valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !in_valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign cfg_ready = 1'b1;

	always_comb begin
		logic a, b, a_rise, a_fall, b_rise, b_fall, both, either, prev_both;
		logic a_hold, b_hold;
		a         = in_s1.a_down;
		b         = in_s1.b_down;
		a_rise    = a && !a_prev_q;
		a_fall    = !a && a_prev_q;
		b_rise    = b && !b_prev_q;
		b_fall    = !b && b_prev_q;
		both      = a && b;
		either    = a || b;
		prev_both = a_prev_q && b_prev_q;

		n_a_press = sat_inc(a_press_q);
		n_b_press = sat_inc(b_press_q);
		n_ct      = sat_inc(chord_tmr_q);
		n_a_srep  = sat_inc(a_srep_q);
		n_b_srep  = sat_inc(b_srep_q);
		n_a_srel  = sat_inc(a_srel_q);
		n_b_srel  = sat_inc(b_srel_q);
		n_a_seen  = a_seen_q;
		n_b_seen  = b_seen_q;

		if (a_rise) begin
			n_a_press = '0;
			n_a_seen  = 1'b0;
		end
		a_hold = a && !n_a_seen && (n_a_press >= hold_cfg_q);
		if (a_hold) begin
			n_a_seen = 1'b1;
		end
		if (b_rise) begin
			n_b_press = '0;
			n_b_seen  = 1'b0;
		end
		b_hold = b && !n_b_seen && (n_b_press >= hold_cfg_q);
		if (b_hold) begin
			n_b_seen = 1'b1;
		end

		if (!both || !prev_both) begin
			n_ct = '0;
		end
		n_cf     = chord_fired_q;
		n_a_held = a_held_q;
		n_b_held = b_held_q;
		if (!either) begin
			if (n_cf) begin
				n_a_held = 1'b0;
				n_b_held = 1'b0;
			end
			n_cf = 1'b0;
		end

		n_a_taps = a_taps_q;
		n_b_taps = b_taps_q;
		n_a_alt  = a_alt_q;
		n_b_alt  = b_alt_q;
		n_a_pend = a_pend_q;
		res      = '0;

		if (both && !n_cf && (n_ct >= chord_cfg_q)) begin
			n_cf            = 1'b1;
			n_a_held        = 1'b1;
			n_b_held        = 1'b1;
			n_a_srep        = '0;
			n_a_pend        = 1'b0;
			n_a_taps        = '0;
			n_b_taps        = '0;
			res.chord_event = 1'b1;
		end else if (!n_cf && !both) begin
			// button B
			if (b_rise) begin
				n_b_taps = (!n_b_held && (n_b_srel <= tap_win_cfg_q)) ? tap_inc(n_b_taps) : TAP_ONE;
			end
			if (b_hold) begin
				n_b_alt     = n_b_taps >= TAP_TWO;
				n_b_taps    = '0;
				res.b_event = n_b_alt ? BEV_HOLD_ALT : BEV_HOLD;
				n_b_held    = 1'b1;
				n_b_srep    = '0;
			end
			if (n_b_held && b && (n_b_srep >= b_rep_cfg_q)) begin
				if (!n_b_alt) begin
					res.b_event = BEV_HOLD;
				end
				n_b_srep = '0;
			end
			if (b_fall) begin
				n_b_srel = '0;
				if (!n_b_held) begin
					res.b_event = BEV_PRESS;
				end
				n_b_held = 1'b0;
			end

			// button A
			if (a_rise) begin
				n_a_taps = (!n_a_held && (n_a_srel <= tap_win_cfg_q)) ? tap_inc(n_a_taps) : TAP_ONE;
			end
			if (a_hold) begin
				n_a_pend    = 1'b0;
				n_a_alt     = n_a_taps >= TAP_TWO;
				n_a_taps    = '0;
				res.a_event = n_a_alt ? AEV_HOLD_ALT : AEV_HOLD;
				n_a_held    = 1'b1;
				n_a_srep    = '0;
			end
			if (n_a_held && a && (n_a_srep >= a_rep_cfg_q)) begin
				res.a_event = n_a_alt ? AEV_HOLD_ALT : AEV_HOLD_REPEAT;
				n_a_srep    = '0;
			end
			if (a_fall) begin
				n_a_srel = '0;
				if (!n_a_held) begin
					n_a_pend = 1'b1;
				end
				n_a_held = 1'b0;
			end
			if (n_a_pend && !a && (n_a_srel > tap_win_cfg_q)) begin
				if (n_a_taps >= TAP_MAX) begin
					res.a_event = AEV_QUAD;
				end else if (n_a_taps == TAP_THREE) begin
					res.a_event = AEV_TRIPLE;
				end else begin
					res.a_event = AEV_SINGLE;
				end
				n_a_pend = 1'b0;
				n_a_taps = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chord_cfg_q   <= RST_CHORD_HOLD;
			a_rep_cfg_q   <= RST_A_REPEAT;
			b_rep_cfg_q   <= RST_B_REPEAT;
			tap_win_cfg_q <= RST_TAP_WINDOW;
			hold_cfg_q    <= RST_HOLD;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_CHORD_HOLD: chord_cfg_q   <= cfg_data;
				REG_A_REPEAT:   a_rep_cfg_q   <= cfg_data;
				REG_B_REPEAT:   b_rep_cfg_q   <= cfg_data;
				REG_TAP_WINDOW: tap_win_cfg_q <= cfg_data;
				REG_HOLD:       hold_cfg_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_prev_q      <= 1'b0;
			b_prev_q      <= 1'b0;
			a_seen_q      <= 1'b0;
			b_seen_q      <= 1'b0;
			chord_fired_q <= 1'b0;
			a_held_q      <= 1'b0;
			b_held_q      <= 1'b0;
			a_alt_q       <= 1'b0;
			b_alt_q       <= 1'b0;
			a_pend_q      <= 1'b0;
			a_press_q     <= '0;
			b_press_q     <= '0;
			chord_tmr_q   <= '0;
			a_srep_q      <= '0;
			b_srep_q      <= '0;
			a_srel_q      <= '1;
			b_srel_q      <= '1;
			a_taps_q      <= '0;
			b_taps_q      <= '0;
		end else if (advance) begin
			a_prev_q      <= in_s1.a_down;
			b_prev_q      <= in_s1.b_down;
			a_seen_q      <= n_a_seen;
			b_seen_q      <= n_b_seen;
			chord_fired_q <= n_cf;
			a_held_q      <= n_a_held;
			b_held_q      <= n_b_held;
			a_alt_q       <= n_a_alt;
			b_alt_q       <= n_b_alt;
			a_pend_q      <= n_a_pend;
			a_press_q     <= n_a_press;
			b_press_q     <= n_b_press;
			chord_tmr_q   <= n_ct;
			a_srep_q      <= n_a_srep;
			b_srep_q      <= n_b_srep;
			a_srel_q      <= n_a_srel;
			b_srel_q      <= n_b_srel;
			a_taps_q      <= n_a_taps;
			b_taps_q      <= n_b_taps;
		end
	end

endmodule

@@ hdl/tbgd_checker.sv @@
// ---------------------------------------------------------------------------
// tbgd_checker
// Port-level checks of the gesture decoder, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tbgd_checker
	import tbgd_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input tbgd_out_t out_data
);

	`TBGD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
	`TBGD_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_data), "result changed while stalled")
	`TBGD_ASSERT(a_chord_alone, (out_valid && out_data.chord_event) |-> (out_data.a_event == AEV_NONE && out_data.b_event == BEV_NONE), "chord shown with button event")
	`TBGD_ASSERT(a_aev_code, out_valid |-> (out_data.a_event <= AEV_HOLD_REPEAT), "undefined A event code")
	`TBGD_ASSERT(a_ready_empty, !out_valid |-> in_ready, "input blocked with empty output")

endmodule

bind two_button_gesture_decoder tbgd_checker u_tbgd_checker (.*);
